[rtl/column_zscore_standardizer_assert.svh]
// Assertion helpers for the column z-score standardizer.
// Both macros sample on i_clk and are quiet while i_rst_n is low.
`ifndef COLUMN_ZSCORE_STANDARDIZER_ASSERT_SVH
`define COLUMN_ZSCORE_STANDARDIZER_ASSERT_SVH

`ifndef SYNTHESIS
`define ZS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("zscore assertion failed");
`define ZS_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("zscore forbidden condition seen");
`else
`define ZS_ASSERT(lbl, prop)
`define ZS_ASSERT_NEVER(lbl, expr)
`endif

`endif

[rtl/zs_pkg.sv]
package zs_pkg;

    localparam int SAMPLE_W = 24;
    localparam int E_W      = 25;   // sample minus mean
    localparam int SQ_W     = 50;   // e * e
    localparam int Q_W      = 56;   // sum of squared deviations
    localparam int TOTAL_W  = 31;
    localparam int DVD_W    = 64;
    localparam int DVS_W    = 32;
    localparam int SCORE_W  = 16;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_CONST = 2'd1;
    localparam logic [1:0] STAT_FEW   = 2'd2;
    localparam logic [1:0] STAT_MANY  = 2'd3;

    typedef enum logic [3:0] {
        S_LOAD,
        S_MEAN,
        S_MEAN_W,
        S_SQ_RD,
        S_SQ_E,
        S_SQ_MUL,
        S_SQ_ACC,
        S_VAR,
        S_VAR_W,
        S_ROOT,
        S_ROOT_W,
        S_Z_RD,
        S_Z_E,
        S_Z_DIV,
        S_Z_W,
        S_EMIT
    } t_state;

endpackage

[rtl/column_zscore_standardizer.sv]
// Column z-score standardizer. Samples (signed Q11.12) are taken one per cycle
// and stored in a sample RAM until the one marked final. The block then works
// out the rounded mean, the sample variance (over count minus one) and its root,
// and streams one Q3.12 saturated z-score per stored sample in arrival order,
// run_end on the last. Errors (constant column, fewer than two samples, more
// than MAX_ROWS samples) give a single result with score 0 and run_end set.
// After the final sample the block finds the mean, then makes one pass over
// the samples for the squared deviations (RAM read, subtract, multiply,
// accumulate), then the variance and its root, then each score; the shared
// 64-step radix-2 divider does the mean, variance and score divisions. No
// samples are taken until the run has been handed to the output register.
module column_zscore_standardizer #(
    parameter int MAX_ROWS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [zs_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                               i_final_req,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [zs_pkg::SCORE_W-1:0]  o_score,
    output logic [1:0]                         o_status,
    output logic                               o_run_end
);

`include "column_zscore_standardizer_assert.svh"

    localparam int CNT_W = $clog2(MAX_ROWS + 1);
    localparam int AW    = $clog2(MAX_ROWS);

    zs_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0]                   r_cnt;
    logic [CNT_W-1:0]                   r_idx;
    logic signed [zs_pkg::TOTAL_W-1:0]  r_total;
    logic                               r_ovf;
    logic signed [zs_pkg::E_W-1:0]      r_mean;
    logic signed [zs_pkg::E_W-1:0]      r_e;
    logic [zs_pkg::SQ_W-1:0]            r_sq;
    logic [zs_pkg::Q_W-1:0]             r_q;
    logic [zs_pkg::DVS_W-1:0]           r_sd;
    logic signed [zs_pkg::SCORE_W-1:0]  r_res_score;
    logic [1:0]                         r_res_stat;
    logic                               r_res_end;
    logic                               r_o_valid;
    logic signed [zs_pkg::SCORE_W-1:0]  r_o_score;
    logic [1:0]                         r_o_status;
    logic                               r_o_run_end;

    logic                               in_acc;
    logic                               wr_room;
    logic [CNT_W-1:0]                   cnt_eff;
    logic                               ovf_eff;
    logic                               ram_we;
    logic                               out_load;
    logic                               div_start;
    logic [zs_pkg::DVD_W-1:0]           div_dvd;
    logic [zs_pkg::DVS_W-1:0]           div_dvs;
    logic                               div_busy;
    logic                               div_done;
    logic [zs_pkg::DVD_W-1:0]           div_q;
    logic                               sqrt_start;
    logic                               sqrt_done;
    logic [zs_pkg::DVS_W-1:0]           sqrt_root;
    logic signed [zs_pkg::SAMPLE_W-1:0] rd_data;
    logic [zs_pkg::TOTAL_W-1:0]         tot_mag;
    logic [zs_pkg::E_W-1:0]             e_mag;
    logic signed [zs_pkg::E_W-1:0]      e_nx;
    logic signed [2*zs_pkg::E_W-1:0]    sq_full;
    logic signed [zs_pkg::SCORE_W-1:0]  sat_score;
    logic                               last_idx;

    assign in_acc   = i_valid && o_ready;
    assign wr_room  = r_cnt < CNT_W'(MAX_ROWS);
    assign cnt_eff  = wr_room ? r_cnt + 1'b1 : r_cnt;
    assign ovf_eff  = r_ovf || !wr_room;
    assign tot_mag  = r_total < 0 ? zs_pkg::TOTAL_W'(-r_total) : zs_pkg::TOTAL_W'(r_total);
    assign e_nx     = zs_pkg::E_W'(rd_data) - r_mean;
    assign e_mag    = r_e < 0 ? zs_pkg::E_W'(-r_e) : zs_pkg::E_W'(r_e);
    assign sq_full  = r_e * r_e;
    assign last_idx = (r_idx + 1'b1) == r_cnt;

    always_comb begin
        if (r_e < 0) begin
            sat_score = (div_q > zs_pkg::DVD_W'(32768)) ? 16'sh8000
                                                       : zs_pkg::SCORE_W'(-div_q);
        end else begin
            sat_score = (div_q > zs_pkg::DVD_W'(32767)) ? 16'sh7FFF
                                                       : zs_pkg::SCORE_W'(div_q);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            zs_pkg::S_LOAD: begin
                if (in_acc && i_final_req) begin
                    if (ovf_eff || cnt_eff < CNT_W'(2)) begin
                        n_state = zs_pkg::S_EMIT;
                    end else begin
                        n_state = zs_pkg::S_MEAN;
                    end
                end
            end
            zs_pkg::S_MEAN:   n_state = zs_pkg::S_MEAN_W;
            zs_pkg::S_MEAN_W: if (div_done) n_state = zs_pkg::S_SQ_RD;
            zs_pkg::S_SQ_RD:  n_state = zs_pkg::S_SQ_E;
            zs_pkg::S_SQ_E:   n_state = zs_pkg::S_SQ_MUL;
            zs_pkg::S_SQ_MUL: n_state = zs_pkg::S_SQ_ACC;
            zs_pkg::S_SQ_ACC: n_state = last_idx ? zs_pkg::S_VAR : zs_pkg::S_SQ_RD;
            zs_pkg::S_VAR:    n_state = (r_q == '0) ? zs_pkg::S_EMIT : zs_pkg::S_VAR_W;
            zs_pkg::S_VAR_W:  if (div_done) n_state = zs_pkg::S_ROOT;
            zs_pkg::S_ROOT:   n_state = zs_pkg::S_ROOT_W;
            zs_pkg::S_ROOT_W: begin
                if (sqrt_done) begin
                    n_state = (sqrt_root == '0) ? zs_pkg::S_EMIT : zs_pkg::S_Z_RD;
                end
            end
            zs_pkg::S_Z_RD:   n_state = zs_pkg::S_Z_E;
            zs_pkg::S_Z_E:    n_state = zs_pkg::S_Z_DIV;
            zs_pkg::S_Z_DIV:  n_state = zs_pkg::S_Z_W;
            zs_pkg::S_Z_W:    if (div_done) n_state = zs_pkg::S_EMIT;
            zs_pkg::S_EMIT: begin
                if (out_load) begin
                    n_state = r_res_end ? zs_pkg::S_LOAD : zs_pkg::S_Z_RD;
                end
            end
            default:          n_state = zs_pkg::S_LOAD;
        endcase
    end

    // control outputs
    always_comb begin
        o_ready    = 1'b0;
        ram_we     = 1'b0;
        out_load   = 1'b0;
        div_start  = 1'b0;
        div_dvd    = '0;
        div_dvs    = '0;
        sqrt_start = 1'b0;
        case (r_state)
            zs_pkg::S_LOAD: begin
                o_ready = 1'b1;
                ram_we  = in_acc && wr_room;
            end
            zs_pkg::S_MEAN: begin
                div_start = 1'b1;
                div_dvd   = (zs_pkg::DVD_W'(tot_mag) << 1) + zs_pkg::DVD_W'(r_cnt);
                div_dvs   = zs_pkg::DVS_W'(r_cnt) << 1;
            end
            zs_pkg::S_VAR: begin
                div_start = r_q != '0;
                div_dvd   = {r_q, 8'd0};
                div_dvs   = zs_pkg::DVS_W'(r_cnt - 1'b1);
            end
            zs_pkg::S_ROOT: begin
                sqrt_start = 1'b1;
            end
            zs_pkg::S_Z_DIV: begin
                div_start = 1'b1;
                div_dvd   = (zs_pkg::DVD_W'(e_mag) << 17) + zs_pkg::DVD_W'(r_sd);
                div_dvs   = {r_sd[zs_pkg::DVS_W-2:0], 1'b0};
            end
            zs_pkg::S_EMIT: begin
                out_load = !r_o_valid || i_ready;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= zs_pkg::S_LOAD;
            r_cnt     <= '0;
            r_total   <= '0;
            r_ovf     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                if (wr_room) begin
                    r_cnt   <= r_cnt + 1'b1;
                    r_total <= r_total + zs_pkg::TOTAL_W'(i_sample);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (out_load && r_res_end) begin
                r_cnt   <= '0;
                r_total <= '0;
                r_ovf   <= 1'b0;
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            zs_pkg::S_LOAD: begin
                r_res_score <= '0;
                r_res_end   <= 1'b1;
                r_res_stat  <= ovf_eff ? zs_pkg::STAT_MANY : zs_pkg::STAT_FEW;
            end
            zs_pkg::S_MEAN: begin
                r_q <= '0;
            end
            zs_pkg::S_MEAN_W: begin
                if (div_done) begin
                    r_mean <= (r_total < 0) ? -zs_pkg::E_W'(div_q)
                                            : zs_pkg::E_W'(div_q);
                    r_idx  <= '0;
                end
            end
            zs_pkg::S_SQ_E:   r_e  <= e_nx;
            zs_pkg::S_SQ_MUL: r_sq <= sq_full[zs_pkg::SQ_W-1:0];
            zs_pkg::S_SQ_ACC: begin
                r_q   <= r_q + zs_pkg::Q_W'(r_sq);
                r_idx <= r_idx + 1'b1;
            end
            zs_pkg::S_VAR: begin
                r_res_score <= '0;
                r_res_stat  <= zs_pkg::STAT_CONST;
                r_res_end   <= 1'b1;
            end
            zs_pkg::S_ROOT_W: begin
                if (sqrt_done) begin
                    r_sd        <= sqrt_root;
                    r_idx       <= '0;
                    r_res_score <= '0;
                    r_res_stat  <= zs_pkg::STAT_CONST;
                    r_res_end   <= 1'b1;
                end
            end
            zs_pkg::S_Z_E: r_e <= e_nx;
            zs_pkg::S_Z_W: begin
                if (div_done) begin
                    r_res_score <= sat_score;
                    r_res_stat  <= zs_pkg::STAT_OK;
                    r_res_end   <= last_idx;
                end
            end
            zs_pkg::S_EMIT: begin
                if (out_load) begin
                    r_o_score   <= r_res_score;
                    r_o_status  <= r_res_stat;
                    r_o_run_end <= r_res_end;
                    r_idx       <= r_idx + 1'b1;
                end
            end
            default: begin
                r_sq <= r_sq;
            end
        endcase
    end

    zs_ram #(
        .WIDTH (zs_pkg::SAMPLE_W),
        .DEPTH (MAX_ROWS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (i_sample),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rd_data)
    );

    zs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    zs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_value (div_q),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    assign o_valid   = r_o_valid;
    assign o_score   = r_o_score;
    assign o_status  = r_o_status;
    assign o_run_end = r_o_run_end;

    `ZS_ASSERT(a_cnt_bound, r_cnt <= CNT_W'(MAX_ROWS))
    `ZS_ASSERT(a_div_idle_start, div_start |-> !div_busy)
    `ZS_ASSERT(a_ok_idx_in_run, (r_state == zs_pkg::S_EMIT && r_res_stat == zs_pkg::STAT_OK) |-> r_idx < r_cnt)
    `ZS_ASSERT(a_err_single, (o_valid && o_status != zs_pkg::STAT_OK) |-> (o_run_end && o_score == '0))

endmodule

[rtl/zs_ram.sv]
module zs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/zs_div.sv]
// Restoring divider, one quotient bit per cycle.
module zs_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [zs_pkg::DVD_W-1:0] i_dividend,
    input  logic [zs_pkg::DVS_W-1:0] i_divisor,
    output logic                     o_busy,
    output logic                     o_done,
    output logic [zs_pkg::DVD_W-1:0] o_quotient
);

    localparam int CW = $clog2(zs_pkg::DVD_W);

    logic                     r_busy;
    logic                     r_done;
    logic [CW-1:0]            r_cnt;
    logic [zs_pkg::DVD_W-1:0] r_dvd;
    logic [zs_pkg::DVS_W-1:0] r_dvs;
    logic [zs_pkg::DVS_W-1:0] r_rem;

    logic [zs_pkg::DVS_W:0]   rem_sh;
    logic [zs_pkg::DVS_W:0]   diff;
    logic                     ge;

    assign rem_sh = {r_rem, r_dvd[zs_pkg::DVD_W-1]};
    assign diff   = rem_sh - {1'b0, r_dvs};
    assign ge     = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(zs_pkg::DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[zs_pkg::DVS_W-1:0] : rem_sh[zs_pkg::DVS_W-1:0];
            r_dvd <= {r_dvd[zs_pkg::DVD_W-2:0], ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_dvd;

endmodule

[rtl/zs_sqrt.sv]
// Floor square root, two radicand bits per cycle.
module zs_sqrt (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [zs_pkg::DVD_W-1:0] i_value,
    output logic                     o_done,
    output logic [zs_pkg::DVS_W-1:0] o_root
);

    logic                     r_busy;
    logic                     r_done;
    logic [zs_pkg::DVD_W-1:0] r_v;
    logic [zs_pkg::DVD_W-1:0] r_r;
    logic [zs_pkg::DVD_W-1:0] r_bit;
    logic [zs_pkg::DVD_W-1:0] trial;

    assign trial = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_value;
            r_r   <= '0;
            r_bit <= {2'b01, {(zs_pkg::DVD_W-2){1'b0}}};
        end else if (r_busy) begin
            if (r_v >= trial) begin
                r_v <= r_v - trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[zs_pkg::DVS_W-1:0];

endmodule
